>>> rtl/round_robin_service_lookup_macros.svh
// Assertion macros for the round-robin service lookup sequencer.
`ifndef ROUND_ROBIN_SERVICE_LOOKUP_MACROS_SVH
`define ROUND_ROBIN_SERVICE_LOOKUP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RRSL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RRSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rrsl_pkg.sv
// Shared constants and controller/datapath interface types.
package rrsl_pkg;

    localparam int MAX_JOBS_DEF = 1024;
    localparam int DEMAND_W     = 32;
    localparam int TICK_W       = 48;
    localparam int DIV_CNT_W    = $clog2(TICK_W + 1);

    typedef struct packed {
        logic load;
        logic init;
        logic scan_clr;
        logic scan_en;
        logic pick;
        logic mul;
        logic advance;
        logic div_start;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic live_zero;
        logic fits;
        logic div_done;
        logic hit;
    } status_t;

endpackage

>>> rtl/round_robin_service_lookup.sv
// Top level of the round-robin service lookup block.
// Items with kind 0 append a job demand to the table; once MAX_JOBS jobs
// are held further loads are dropped. An item with kind 1 asks which job is
// served at the given zero-based tick, returns one result item (found,
// 1-based position, or 0/0 when every demand is spent by then) and empties
// the table. A query walks the table once per distinct demand level reached:
// each walk reads one entry a cycle from the demand memory (one write port,
// one registered read port), and the level's cost is then formed and
// compared. The level that holds the tick is resolved by a bit-serial
// remainder of 48 steps and one more walk that picks the live job. Loads are
// taken while a result item waits on the output; a new query waits until
// that result has been taken.
module round_robin_service_lookup
#(
    parameter int MAX_JOBS = rrsl_pkg::MAX_JOBS_DEF,
    parameter int CW       = $clog2(MAX_JOBS + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [rrsl_pkg::DEMAND_W-1:0] demand,
    input  logic [rrsl_pkg::TICK_W-1:0]   tick,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [CW-1:0]                 position
);
    import rrsl_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer: owns the handshakes and steps the datapath.
    rrsl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: table, scans, cost, remainder and result register.
    rrsl_dpath #(
        .MAX_JOBS (MAX_JOBS),
        .CW       (CW)
    ) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .demand   (demand),
        .tick     (tick),
        .status   (status),
        .found    (found),
        .position (position)
    );

endmodule

>>> rtl/rrsl_ctrl.sv
// Query sequencer: steps scans, multiply, compare, divide and pick.
module rrsl_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             kind,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  rrsl_pkg::status_t status,
    output rrsl_pkg::cmd_t    cmd
);
    import rrsl_pkg::*;

    `include "round_robin_service_lookup_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_PICK,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE) | (out_valid_reg & kind);
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !kind)
                begin
                    cmd.load = 1'b1;
                end
                else if (accept)
                begin
                    cmd.init     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.live_zero)
                begin
                    state_next = ST_RESULT;
                end
                else if (status.fits)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.advance  = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_PICK;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_PICK:
            begin
                cmd.scan_en = 1'b1;
                cmd.pick    = 1'b1;
                if (status.hit || status.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RRSL_ASSERT_SAME(a_busy_stalls, state_reg != ST_IDLE, in_stall, "busy but not stalling")
    `RRSL_ASSERT_SAME(a_no_overwrite, cmd.finish, !out_valid_reg, "result overwrites item")
    `RRSL_ASSERT_NEXT(a_query_starts, accept && kind, state_reg != ST_IDLE, "query not started")

endmodule

>>> rtl/rrsl_dpath.sv
// Job table, level scan, cost multiply, tick divider and result register.
module rrsl_dpath
#(
    parameter int MAX_JOBS = rrsl_pkg::MAX_JOBS_DEF,
    parameter int CW       = $clog2(MAX_JOBS + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrsl_pkg::cmd_t                cmd,
    input  logic [rrsl_pkg::DEMAND_W-1:0] demand,
    input  logic [rrsl_pkg::TICK_W-1:0]   tick,
    output rrsl_pkg::status_t             status,
    output logic                          found,
    output logic [CW-1:0]                 position
);
    import rrsl_pkg::*;

    localparam int AW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int COSTW = CW + DEMAND_W;
    localparam int XW    = (COSTW > TICK_W) ? COSTW : TICK_W;

    logic [DEMAND_W-1:0] demand_mem [MAX_JOBS];
    logic [DEMAND_W-1:0] rd_data_reg;

    logic [CW-1:0]        count_reg, n_reg, addr_reg, live_reg, rd_idx_reg;
    logic                 rd_valid_reg;
    logic [DEMAND_W-1:0]  level_reg, min_reg;
    logic [TICK_W-1:0]    tick_reg, shift_reg;
    logic [COSTW-1:0]     cost_reg;
    logic [CW-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 hit_reg, found_reg;
    logic [CW-1:0]        pos_reg, out_pos_reg;

    logic       issue, is_live;
    logic [CW:0] rem_try;
    logic [CW:0] rem_sub;

    assign issue   = cmd.scan_en && (addr_reg != n_reg) && !hit_reg;
    assign is_live = rd_data_reg > level_reg;
    assign rem_try = {rem_reg, shift_reg[TICK_W-1]};
    assign rem_sub = rem_try - {1'b0, live_reg};

    assign status.scan_done = (addr_reg == n_reg) && !rd_valid_reg;
    assign status.live_zero = (live_reg == '0);
    assign status.fits      = XW'(tick_reg) < XW'(cost_reg);
    assign status.div_done  = (div_cnt_reg == DIV_CNT_W'(TICK_W));
    assign status.hit       = hit_reg;

    assign found    = found_reg;
    assign position = out_pos_reg;

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg != CW'(MAX_JOBS)))
        begin
            demand_mem[count_reg[AW-1:0]] <= demand;
        end
        rd_data_reg <= demand_mem[addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            n_reg        <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            div_cnt_reg  <= '0;
            live_reg     <= '0;
        end
        else
        begin
            if (cmd.load && (count_reg != CW'(MAX_JOBS)))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.init)
            begin
                n_reg     <= count_reg;
                count_reg <= '0;
                hit_reg   <= 1'b0;
            end
            rd_valid_reg <= issue;
            rd_idx_reg   <= addr_reg;
            if (issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (rd_valid_reg && is_live && !hit_reg)
            begin
                if (cmd.pick && (live_reg == rem_reg))
                begin
                    hit_reg <= 1'b1;
                    pos_reg <= rd_idx_reg + 1'b1;
                end
                live_reg <= live_reg + 1'b1;
                if (rd_data_reg < min_reg)
                begin
                    min_reg <= rd_data_reg;
                end
            end
            // Clear wins: no data is in flight when a scan restarts.
            if (cmd.scan_clr)
            begin
                addr_reg <= '0;
                live_reg <= '0;
                min_reg  <= '1;
            end
            if (cmd.mul)
            begin
                cost_reg <= COSTW'(live_reg) * COSTW'(min_reg - level_reg);
            end
            if (cmd.advance)
            begin
                tick_reg  <= tick_reg - TICK_W'(cost_reg);
                level_reg <= min_reg;
            end
            if (cmd.init)
            begin
                tick_reg  <= tick;
                level_reg <= '0;
            end
            if (cmd.div_start)
            begin
                shift_reg   <= tick_reg;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                shift_reg   <= shift_reg << 1;
                rem_reg     <= rem_sub[CW] ? rem_try[CW-1:0] : rem_sub[CW-1:0];
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                found_reg   <= hit_reg;
                out_pos_reg <= hit_reg ? pos_reg : '0;
            end
        end
    end

endmodule
